// ----- rtl/i2cm_pkg.sv -----
// Shared types, codes and field layout for the I2C register-access master.
// No dependencies.
package i2cm_pkg;

    localparam int unsigned IN_DATA_W  = 32;
    localparam int unsigned IN_USER_W  = 2;
    localparam int unsigned OUT_DATA_W = 16;
    localparam int unsigned TICKS_W    = 16;

    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    localparam logic [1:0] FAULT_NONE  = 2'd0;
    localparam logic [1:0] FAULT_BUSY  = 2'd1;
    localparam logic [1:0] FAULT_ERROR = 2'd2;

    // queued item: classified command plus payload
    typedef struct packed {
        logic       is_cmd;
        logic       is_rd;
        logic [7:0] device;
        logic [7:0] reg_idx;
        logic [7:0] data;
        logic       sda;
    } t_item;

endpackage

// ----- rtl/i2c_master_register_access_core.sv -----
// Top level of the I2C single-byte register read/write master.
// Depends on i2cm_pkg, i2cm_front and i2cm_back.
//
// Every input transfer is one bus tick carrying an op (tick, start write, start
// read) and the sampled SDA level; it yields exactly one output transfer with
// the SCL/SDA levels to drive and the status. Throughput is one item per clock
// while the output does not stall; items pass a two-entry input queue, then the
// sequencer's output register. Output back-pressure stalls the sequencer and
// fills the queue. phase_ticks sets the number of items per bus phase; the user
// must write it only while no transaction runs (the block does not enforce it).
module i2c_master_register_access_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,       // phase_ticks
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // [7:0] device_byte, [15:8] register_index, [23:16] write_byte,
    // [24] sda_level, [31:25] zero
    input  logic [31:0] i_s_tdata,
    input  logic [1:0]  i_s_tuser,         // [1:0] op
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // [0] scl_drive, [1] sda_release, [2] busy_res, [3] done_res,
    // [11:4] read_byte, [13:12] start_fault, [14] nack_seen, [15] command_dropped
    output logic [15:0] o_m_tdata
);
    import i2cm_pkg::*;

    logic  w_item_valid;
    t_item w_item;
    logic  w_item_pop;

    i2cm_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (i_s_tvalid),
        .o_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .i_s_tuser    (i_s_tuser),
        .o_item_valid (w_item_valid),
        .o_item       (w_item),
        .i_item_pop   (w_item_pop)
    );

    i2cm_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_item_valid (w_item_valid),
        .i_item       (w_item),
        .o_item_pop   (w_item_pop),
        .o_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .o_m_tdata    (o_m_tdata)
    );

`ifndef SYNTHESIS
    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> !(o_m_tdata[3] && o_m_tdata[2]))
        else $error("done reported while still busy");

    a_drop_only_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tdata[15]) |-> (o_m_tdata[2] || o_m_tdata[3]))
        else $error("command dropped while sequencer idle");

    a_fault_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[13:12] != 2'd3))
        else $error("invalid start fault code");

    a_pop_has_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_item_pop |-> w_item_valid)
        else $error("sequencer consumed from empty queue");
`endif

endmodule

// ----- rtl/i2cm_front.sv -----
// Input side: takes stream transfers, classifies the op code and queues items.
// Depends on i2cm_pkg.
module i2cm_front (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_s_tvalid,
    output logic                     o_s_tready,
    input  logic [i2cm_pkg::IN_DATA_W-1:0] i_s_tdata,
    input  logic [i2cm_pkg::IN_USER_W-1:0] i_s_tuser,
    output logic                     o_item_valid,
    output i2cm_pkg::t_item          o_item,
    input  logic                     i_item_pop
);
    import i2cm_pkg::*;

    localparam int unsigned DEPTH = 2;

    t_item      r_mem [DEPTH];
    logic       r_wr_ptr, n_wr_ptr;
    logic       r_rd_ptr, n_rd_ptr;
    logic [1:0] r_count, n_count;
    t_item      w_item;
    logic       w_push;
    logic       w_pop;

    always_comb begin
        w_item.is_cmd  = (i_s_tuser == OP_WRITE) || (i_s_tuser == OP_READ);
        w_item.is_rd   = (i_s_tuser == OP_READ);
        w_item.device  = i_s_tdata[7:0];
        w_item.reg_idx = i_s_tdata[15:8];
        w_item.data    = i_s_tdata[23:16];
        w_item.sda     = i_s_tdata[24];
    end

    assign o_s_tready   = (r_count != 2'(DEPTH));
    assign w_push       = i_s_tvalid && o_s_tready;
    assign o_item_valid = (r_count != 2'd0);
    assign w_pop        = i_item_pop && o_item_valid;
    assign o_item       = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = w_push ? ~r_wr_ptr : r_wr_ptr;
        n_rd_ptr = w_pop ? ~r_rd_ptr : r_rd_ptr;
        n_count  = r_count;
        if (w_push && !w_pop) begin
            n_count = r_count + 2'd1;
        end else if (!w_push && w_pop) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= w_item;
        end
    end

endmodule

// ----- rtl/i2cm_back.sv -----
// Bus sequencer: runs start/byte/ack/stop phases per item and registers results.
// Depends on i2cm_pkg.
module i2cm_back (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [i2cm_pkg::TICKS_W-1:0] i_cfg_wdata,
    input  logic                      i_item_valid,
    input  i2cm_pkg::t_item           i_item,
    output logic                      o_item_pop,
    output logic                      o_m_tvalid,
    input  logic                      i_m_tready,
    output logic [i2cm_pkg::OUT_DATA_W-1:0] o_m_tdata
);
    import i2cm_pkg::*;

    typedef enum logic [1:0] {
        KIND_START = 2'd0,
        KIND_TX    = 2'd1,
        KIND_RX    = 2'd2,
        KIND_STOP  = 2'd3
    } t_kind;

    function automatic t_kind f_kind(input logic rd, input logic [2:0] stage);
        t_kind k;
        k = KIND_STOP;
        if (rd) begin
            unique case (stage)
                3'd0, 3'd3:       k = KIND_START;
                3'd1, 3'd2, 3'd4: k = KIND_TX;
                3'd5:             k = KIND_RX;
                default:          k = KIND_STOP;
            endcase
        end else begin
            unique case (stage)
                3'd0:             k = KIND_START;
                3'd1, 3'd2, 3'd3: k = KIND_TX;
                default:          k = KIND_STOP;
            endcase
        end
        return k;
    endfunction

    // lines = {scl, sda}
    function automatic logic [1:0] f_enter(input t_kind k, input logic [1:0] m,
                                           input logic [3:0] bc, input logic msb,
                                           input logic [1:0] lines);
        logic [1:0] l;
        l = lines;
        unique case (k)
            KIND_START: begin
                unique case (m)
                    2'd0: l[0] = 1'b1;
                    2'd1: l[1] = 1'b1;
                    2'd2: l[0] = 1'b0;
                    default: l[1] = 1'b0;
                endcase
            end
            KIND_TX: begin
                if (!bc[3]) begin
                    if (m == 2'd0) begin
                        l = {1'b0, msb};
                    end else if (m == 2'd1) begin
                        l[1] = 1'b1;
                    end else begin
                        l[1] = 1'b0;
                    end
                end else if (m == 2'd0) begin
                    l[0] = 1'b1;
                end else begin
                    l[1] = 1'b1;
                end
            end
            KIND_RX: begin
                if (!bc[3]) begin
                    if (m == 2'd0) begin
                        l = 2'b11;
                    end else begin
                        l[1] = 1'b0;
                    end
                end else if (m == 2'd0) begin
                    l[0] = 1'b1;
                end else if (m == 2'd1) begin
                    l[1] = 1'b1;
                end else begin
                    l[1] = 1'b0;
                end
            end
            default: begin
                if (m == 2'd0) begin
                    l[0] = 1'b0;
                end else if (m == 2'd1) begin
                    l[1] = 1'b1;
                end else begin
                    l[0] = 1'b1;
                end
            end
        endcase
        return l;
    endfunction

    logic [TICKS_W-1:0] r_phase_ticks;
    logic               r_idle, n_idle;
    logic [2:0]         r_stage, n_stage;
    logic [1:0]         r_m, n_m;
    logic [3:0]         r_bit, n_bit;
    logic [7:0]         r_shift, n_shift;
    logic [TICKS_W-1:0] r_tick, n_tick;
    logic [7:0]         r_dev, n_dev;
    logic [7:0]         r_reg, n_reg;
    logic [7:0]         r_data, n_data;
    logic               r_is_read, n_is_read;
    logic [1:0]         r_fault, n_fault;
    logic               r_nack, n_nack;
    logic               r_scl, n_scl;
    logic               r_sda, n_sda;
    logic [7:0]         r_last, n_last;
    logic               r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;

    logic [OUT_DATA_W-1:0] w_result;
    logic                  w_pop;

    always_comb begin
        logic [1:0]         v_lines;
        logic [1:0]         v_shown;
        logic               v_done;
        logic               v_drop;
        logic               v_next;
        logic               v_adv;
        logic [1:0]         v_m;
        t_kind              v_kind;
        logic [TICKS_W-1:0] v_limit;
        logic [2:0]         v_stage1;
        logic [2:0]         v_count;

        n_idle    = r_idle;
        n_stage   = r_stage;
        n_m       = r_m;
        n_bit     = r_bit;
        n_shift   = r_shift;
        n_tick    = r_tick;
        n_dev     = r_dev;
        n_reg     = r_reg;
        n_data    = r_data;
        n_is_read = r_is_read;
        n_fault   = r_fault;
        n_nack    = r_nack;
        n_last    = r_last;
        v_lines   = {r_scl, r_sda};
        v_shown   = v_lines;
        v_done    = 1'b0;
        v_drop    = 1'b0;
        v_next    = 1'b0;
        v_adv     = 1'b0;
        v_m       = r_m;
        v_kind    = f_kind(r_is_read, r_stage);
        v_limit   = (r_phase_ticks == '0) ? TICKS_W'(1) : r_phase_ticks;
        v_stage1  = r_stage + 3'd1;
        v_count   = r_is_read ? 3'd7 : 3'd5;

        if (r_idle) begin
            if (i_item.is_cmd) begin
                n_is_read = i_item.is_rd;
                n_dev     = i_item.device;
                n_reg     = i_item.reg_idx;
                n_data    = i_item.data;
                n_fault   = FAULT_NONE;
                n_nack    = 1'b0;
                n_tick    = '0;
                n_bit     = 4'd0;
                n_idle    = 1'b0;
                n_stage   = 3'd0;
                n_m       = 2'd0;
                v_lines   = f_enter(KIND_START, 2'd0, 4'd0, r_shift[7], v_lines);
            end
            v_shown = v_lines;
        end else begin
            v_drop = i_item.is_cmd;
            if ({1'b0, r_tick} + (TICKS_W+1)'(1) >= {1'b0, v_limit}) begin
                n_tick = '0;
                unique case (v_kind)
                    KIND_START: begin
                        if (r_m == 2'd1 && !i_item.sda) begin
                            n_fault = FAULT_BUSY;
                            v_next  = 1'b1;
                        end else if (r_m == 2'd3) begin
                            if (i_item.sda) begin
                                n_fault = FAULT_ERROR;
                            end
                            v_next = 1'b1;
                        end else begin
                            v_adv = 1'b1;
                            v_m   = r_m + 2'd1;
                        end
                    end
                    KIND_TX: begin
                        if (!r_bit[3]) begin
                            v_adv = 1'b1;
                            if (r_m < 2'd2) begin
                                v_m = r_m + 2'd1;
                            end else begin
                                n_bit   = r_bit + 4'd1;
                                n_shift = {r_shift[6:0], 1'b0};
                                v_m     = 2'd0;
                            end
                        end else if (r_m == 2'd0) begin
                            v_adv = 1'b1;
                            v_m   = 2'd1;
                        end else begin
                            if (i_item.sda) begin
                                n_nack = 1'b1;
                            end
                            v_lines[1] = 1'b0;
                            v_next     = 1'b1;
                        end
                    end
                    KIND_RX: begin
                        if (!r_bit[3]) begin
                            v_adv = 1'b1;
                            if (r_m == 2'd0) begin
                                n_shift = {r_shift[6:0], i_item.sda};
                                v_m     = 2'd1;
                            end else begin
                                n_bit = r_bit + 4'd1;
                                if (r_bit == 4'd7) begin
                                    n_last = r_shift;
                                end
                                v_m = 2'd0;
                            end
                        end else if (r_m < 2'd2) begin
                            v_adv = 1'b1;
                            v_m   = r_m + 2'd1;
                        end else begin
                            v_next = 1'b1;
                        end
                    end
                    default: begin
                        if (r_m < 2'd2) begin
                            v_adv = 1'b1;
                            v_m   = r_m + 2'd1;
                        end else begin
                            v_next = 1'b1;
                        end
                    end
                endcase

                if (v_next) begin
                    n_bit = 4'd0;
                    n_m   = 2'd0;
                    if (v_stage1 >= v_count) begin
                        n_idle = 1'b1;
                        v_done = 1'b1;
                    end else begin
                        n_stage = v_stage1;
                        unique case (v_stage1)
                            3'd1:    n_shift = r_dev;
                            3'd2:    n_shift = r_reg;
                            3'd3:    n_shift = r_data;
                            3'd4:    n_shift = r_dev + 8'd1;
                            default: n_shift = r_shift;
                        endcase
                        v_lines = f_enter(f_kind(r_is_read, v_stage1), 2'd0, 4'd0,
                                          n_shift[7], v_lines);
                    end
                end else if (v_adv) begin
                    n_m     = v_m;
                    v_lines = f_enter(v_kind, v_m, n_bit, n_shift[7], v_lines);
                end
            end else begin
                n_tick = r_tick + TICKS_W'(1);
            end
        end

        n_scl = v_lines[1];
        n_sda = v_lines[0];

        w_result = {v_drop, n_nack, n_fault, n_last, v_done, !n_idle,
                    v_shown[0], v_shown[1]};
    end

    assign w_pop      = i_item_valid && (!r_out_valid || i_m_tready);
    assign o_item_pop = w_pop;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_ticks <= TICKS_W'(1);
            r_idle        <= 1'b1;
            r_stage       <= 3'd0;
            r_m           <= 2'd0;
            r_bit         <= 4'd0;
            r_shift       <= 8'd0;
            r_tick        <= '0;
            r_dev         <= 8'd0;
            r_reg         <= 8'd0;
            r_data        <= 8'd0;
            r_is_read     <= 1'b0;
            r_fault       <= FAULT_NONE;
            r_nack        <= 1'b0;
            r_scl         <= 1'b1;
            r_sda         <= 1'b1;
            r_last        <= 8'd0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_phase_ticks <= i_cfg_wdata;
            end
            if (w_pop) begin
                r_idle      <= n_idle;
                r_stage     <= n_stage;
                r_m         <= n_m;
                r_bit       <= n_bit;
                r_shift     <= n_shift;
                r_tick      <= n_tick;
                r_dev       <= n_dev;
                r_reg       <= n_reg;
                r_data      <= n_data;
                r_is_read   <= n_is_read;
                r_fault     <= n_fault;
                r_nack      <= n_nack;
                r_scl       <= n_scl;
                r_sda       <= n_sda;
                r_last      <= n_last;
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            r_out_data <= w_result;
        end
    end

endmodule

// ----- dv/tb_i2c_master_register_access_core.sv -----
// Testbench for i2c_master_register_access_core: directed table, then random bus
// transactions, checked against an item-by-item sequencer predictor or fixed table values.
// Depends on i2cm_pkg and the RTL top level only.
module tb_i2c_master_register_access_core;
    timeunit 1ns;
    timeprecision 1ps;

    import i2cm_pkg::*;

    localparam logic [1:0]  OP_SPARE     = 2'd3;
    localparam logic [5:0]  STEP_IDLE    = 6'd63;
    localparam int unsigned LIMIT_CYCLES = 1_000_000;
    localparam int unsigned PHASE_BUDGET = 150;
    localparam logic [15:0] PHASE_SET [4] = '{16'd2, 16'd0, 16'd3, 16'd1};

    typedef enum logic [1:0] {SEC_START, SEC_TX, SEC_RX, SEC_STOP} t_sec;

    typedef struct packed {
        logic       dropped;
        logic       nack;
        logic [1:0] fault;
        logic [7:0] rd_byte;
        logic       done;
        logic       busy;
        logic       sda;
        logic       scl;
    } t_status;

    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  dev;
        logic [7:0]  rg;
        logic [7:0]  dat;
        logic        sda;
        logic        typed;
        logic [15:0] want;
        logic        settle;
    } t_row;

    // typed values: idle = lines released; command = lines released, busy
    localparam int unsigned N_ROWS = 19;
    t_row plan [N_ROWS] = '{
        '{OP_TICK,  8'h00, 8'h00, 8'h00, 1'b0, 1'b1, 16'h0003, 1'b0},
        '{OP_SPARE, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b1, 16'h0003, 1'b0},
        '{OP_WRITE, 8'hFF, 8'h00, 8'hFF, 1'b1, 1'b1, 16'h0007, 1'b0},
        '{OP_TICK,  8'h00, 8'h00, 8'h00, 1'b1, 1'b0, 16'h0000, 1'b0},
        '{OP_TICK,  8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 16'h0000, 1'b0}, // bus busy
        '{OP_READ,  8'h12, 8'h34, 8'h56, 1'b1, 1'b0, 16'h0000, 1'b0}, // dropped
        '{OP_SPARE, 8'h00, 8'h00, 8'h00, 1'b1, 1'b0, 16'h0000, 1'b1},
        '{OP_READ,  8'hFF, 8'hFF, 8'h00, 1'b1, 1'b1, 16'h0007, 1'b0}, // dev+1 wraps
        '{OP_TICK,  8'h00, 8'h00, 8'h00, 1'b1, 1'b0, 16'h0000, 1'b0},
        '{OP_TICK,  8'h00, 8'h00, 8'h00, 1'b1, 1'b0, 16'h0000, 1'b0},
        '{OP_TICK,  8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 16'h0000, 1'b0},
        '{OP_TICK,  8'h00, 8'h00, 8'h00, 1'b1, 1'b0, 16'h0000, 1'b1}, // bus error
        '{OP_WRITE, 8'h00, 8'hFF, 8'h00, 1'b0, 1'b0, 16'h0000, 1'b0},
        '{OP_TICK,  8'h00, 8'h00, 8'h00, 1'b1, 1'b0, 16'h0000, 1'b0},
        '{OP_TICK,  8'h00, 8'h00, 8'h00, 1'b1, 1'b0, 16'h0000, 1'b0},
        '{OP_TICK,  8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 16'h0000, 1'b0},
        '{OP_TICK,  8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 16'h0000, 1'b1},
        '{OP_TICK,  8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b0, 16'h0000, 1'b0},
        '{OP_SPARE, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 16'h0000, 1'b0}
    };

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [15:0] i_cfg_wdata;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [31:0] i_s_tdata;   // [7:0] device, [15:8] register, [23:16] data, [24] sda
    logic [1:0]  i_s_tuser;   // [1:0] op
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [15:0] o_m_tdata;   // [0] scl, [1] sda, [2] busy, [3] done, [11:4] read byte,
                              // [13:12] start fault, [14] nack, [15] dropped

    i2c_master_register_access_core i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata)
    );

    // sequencer predictor state
    logic [15:0] phase_cfg;
    logic [5:0]  seq_step;
    logic [3:0]  seq_bits;
    logic [7:0]  seq_shift;
    logic [15:0] seq_ticks;
    logic [7:0]  hold_dev;
    logic [7:0]  hold_reg;
    logic [7:0]  hold_dat;
    logic        rd_mode;
    logic [1:0]  fault_rec;
    logic        nack_rec;
    logic        scl_lvl;
    logic        sda_lvl;
    logic [7:0]  rx_byte;

    t_status     pending_status [$];
    int unsigned mismatches;
    int unsigned items_in;
    int unsigned results_out;
    int unsigned n_cmds;
    int unsigned n_dropped;
    int unsigned n_done;
    bit          calm;
    bit          hold_req;

    function automatic t_sec sec_of(logic [3:0] stage);
        if (rd_mode) begin
            case (stage)
                4'd0, 4'd3:       return SEC_START;
                4'd1, 4'd2, 4'd4: return SEC_TX;
                4'd5:             return SEC_RX;
                default:          return SEC_STOP;
            endcase
        end
        case (stage)
            4'd0:             return SEC_START;
            4'd1, 4'd2, 4'd3: return SEC_TX;
            default:          return SEC_STOP;
        endcase
    endfunction

    function automatic void drive_phase();
        logic [1:0] m;
        m = seq_step[1:0];
        case (sec_of(seq_step[5:2]))
            SEC_START: begin
                case (m)
                    2'd0:    sda_lvl = 1'b1;
                    2'd1:    scl_lvl = 1'b1;
                    2'd2:    sda_lvl = 1'b0;
                    default: scl_lvl = 1'b0;
                endcase
            end
            SEC_TX: begin
                if (seq_bits < 4'd8) begin
                    if (m == 2'd0) begin
                        scl_lvl = 1'b0;
                        sda_lvl = seq_shift[7];
                    end else begin
                        scl_lvl = (m == 2'd1);
                    end
                end else if (m == 2'd0) begin
                    sda_lvl = 1'b1;
                end else begin
                    scl_lvl = 1'b1;
                end
            end
            SEC_RX: begin
                if (seq_bits < 4'd8) begin
                    if (m == 2'd0) begin
                        scl_lvl = 1'b1;
                        sda_lvl = 1'b1;
                    end else begin
                        scl_lvl = 1'b0;
                    end
                end else if (m == 2'd0) begin
                    sda_lvl = 1'b1;
                end else begin
                    scl_lvl = (m == 2'd1);
                end
            end
            default: begin
                if (m == 2'd0) sda_lvl = 1'b0;
                else if (m == 2'd1) scl_lvl = 1'b1;
                else sda_lvl = 1'b1;
            end
        endcase
    endfunction

    function automatic logic next_section();
        logic [3:0] stage;
        stage = seq_step[5:2] + 4'd1;
        seq_bits = 4'd0;
        if (stage >= (rd_mode ? 4'd7 : 4'd5)) begin
            seq_step = STEP_IDLE;
            return 1'b1;
        end
        seq_step = {stage, 2'b00};
        case (stage)
            4'd1:    seq_shift = hold_dev;
            4'd2:    seq_shift = hold_reg;
            4'd3:    seq_shift = hold_dat;
            4'd4:    seq_shift = hold_dev + 8'd1;
            default: ;
        endcase
        drive_phase();
        return 1'b0;
    endfunction

    function automatic void goto_micro(logic [1:0] m);
        seq_step[1:0] = m;
        drive_phase();
    endfunction

    // end of a bus phase with the SDA sample of its last tick
    function automatic logic close_phase(logic sda);
        logic [1:0] m;
        m = seq_step[1:0];
        case (sec_of(seq_step[5:2]))
            SEC_START: begin
                if (m == 2'd1 && !sda) begin
                    fault_rec = FAULT_BUSY;
                    return next_section();
                end
                if (m == 2'd3) begin
                    if (sda) fault_rec = FAULT_ERROR;
                    return next_section();
                end
                goto_micro(m + 2'd1);
                return 1'b0;
            end
            SEC_TX: begin
                if (seq_bits < 4'd8) begin
                    if (m < 2'd2) begin
                        goto_micro(m + 2'd1);
                        return 1'b0;
                    end
                    seq_bits++;
                    seq_shift = seq_shift << 1;
                    goto_micro(2'd0);
                    return 1'b0;
                end
                if (m == 2'd0) begin
                    goto_micro(2'd1);
                    return 1'b0;
                end
                if (sda) nack_rec = 1'b1;
                scl_lvl = 1'b0;
                return next_section();
            end
            SEC_RX: begin
                if (seq_bits < 4'd8) begin
                    if (m == 2'd0) begin
                        seq_shift = {seq_shift[6:0], sda};
                        goto_micro(2'd1);
                        return 1'b0;
                    end
                    seq_bits++;
                    if (seq_bits == 4'd8) rx_byte = seq_shift;
                    goto_micro(2'd0);
                    return 1'b0;
                end
                if (m < 2'd2) begin
                    goto_micro(m + 2'd1);
                    return 1'b0;
                end
                return next_section();
            end
            default: begin
                if (m < 2'd2) begin
                    goto_micro(m + 2'd1);
                    return 1'b0;
                end
                return next_section();
            end
        endcase
    endfunction

    function automatic void predictor_reset();
        phase_cfg = 16'd1;
        seq_step  = STEP_IDLE;
        seq_bits  = '0;
        seq_shift = '0;
        seq_ticks = '0;
        hold_dev  = '0;
        hold_reg  = '0;
        hold_dat  = '0;
        rd_mode   = 1'b0;
        fault_rec = FAULT_NONE;
        nack_rec  = 1'b0;
        scl_lvl   = 1'b1;
        sda_lvl   = 1'b1;
        rx_byte   = '0;
    endfunction

    function automatic t_status bus_step(logic [1:0] op, logic [7:0] dev, logic [7:0] rg,
                                         logic [7:0] dat, logic sda);
        t_status     res;
        logic [15:0] lim;
        logic        is_cmd;
        is_cmd = (op == OP_WRITE) || (op == OP_READ);
        res = '0;
        if (seq_step == STEP_IDLE) begin
            if (is_cmd) begin
                rd_mode   = (op == OP_READ);
                hold_dev  = dev;
                hold_reg  = rg;
                hold_dat  = dat;
                fault_rec = FAULT_NONE;
                nack_rec  = 1'b0;
                seq_ticks = '0;
                seq_bits  = '0;
                seq_step  = '0;
                drive_phase();
                n_cmds++;
            end
            res.scl = scl_lvl;
            res.sda = sda_lvl;
        end else begin
            lim = (phase_cfg == 16'd0) ? 16'd1 : phase_cfg;
            res.dropped = is_cmd;
            res.scl = scl_lvl;
            res.sda = sda_lvl;
            if ({16'd0, seq_ticks} + 32'd1 >= {16'd0, lim}) begin
                seq_ticks = '0;
                res.done = close_phase(sda);
            end else begin
                seq_ticks++;
            end
        end
        res.busy    = (seq_step != STEP_IDLE);
        res.rd_byte = rx_byte;
        res.fault   = fault_rec;
        res.nack    = nack_rec;
        n_dropped += res.dropped;
        n_done    += res.done;
        return res;
    endfunction

    // well-behaved target: acks, drives random read data, else follows the line
    function automatic logic target_sda();
        t_sec kind;
        if (seq_step == STEP_IDLE) return 1'b1;
        kind = sec_of(seq_step[5:2]);
        if (kind == SEC_TX && seq_bits == 4'd8) return 1'b0;
        if (kind == SEC_RX && seq_bits < 4'd8) return 1'($urandom);
        return sda_lvl;
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 70) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send_item(logic [1:0] op, logic [7:0] dev, logic [7:0] rg,
                             logic [7:0] dat, logic sda, logic typed, logic [15:0] want);
        int unsigned gap;
        t_status     got;
        gap = pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= op;
        i_s_tdata  <= {7'd0, sda, dat, rg, dev};
        do @(posedge i_clk); while (!o_s_tready);
        got = bus_step(op, dev, rg, dat, sda);
        pending_status.push_back(typed ? t_status'(want) : got);
        items_in++;
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        while (pending_status.size() != 0) @(posedge i_clk);
    endtask

    task automatic set_phase_ticks(logic [15:0] v);
        wait_drained();
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        phase_cfg = v;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic finish_txn();
        while (seq_step != STEP_IDLE)
            send_item(OP_TICK, 8'($urandom), 8'($urandom), 8'($urandom), target_sda(),
                      1'b0, '0);
    endtask

    task automatic run_phase(int unsigned budget, bit finish_all);
        int unsigned spent;
        int unsigned r;
        bit          paused;
        bit          polite;
        logic [1:0]  op;
        logic        sda;
        spent  = 0;
        paused = 0;
        while (spent < budget) begin
            if ($urandom_range(0, 4) == 0)
                repeat ($urandom_range(1, 3))
                    send_item($urandom_range(0, 1) ? OP_SPARE : OP_TICK, 8'($urandom),
                              8'($urandom), 8'($urandom), 1'($urandom), 1'b0, '0);
            send_item($urandom_range(0, 1) ? OP_READ : OP_WRITE, 8'($urandom),
                      8'($urandom), 8'($urandom), 1'($urandom), 1'b0, '0);
            spent++;
            polite = ($urandom_range(0, 9) < 7);
            while (seq_step != STEP_IDLE && (finish_all || spent < budget)) begin
                r = $urandom_range(0, 99);
                if (r < 3) op = $urandom_range(0, 1) ? OP_READ : OP_WRITE;
                else if (r < 6) op = OP_SPARE;
                else op = OP_TICK;
                if (polite) sda = target_sda() ^ ($urandom_range(0, 19) == 0);
                else sda = 1'($urandom);
                send_item(op, 8'($urandom), 8'($urandom), 8'($urandom), sda, 1'b0, '0);
                spent++;
                if (!paused && spent > budget / 2) begin
                    paused = 1;
                    wait_drained();
                end
            end
        end
    endtask

    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        repeat (LIMIT_CYCLES) @(posedge i_clk);
        $display("timeout after %0d cycles, %0d results pending", LIMIT_CYCLES,
                 pending_status.size());
        $display("[FAIL] regression broken");
        $finish;
    end

    // output side: random stalls, plus one long hold-off on request
    initial begin
        int unsigned stall_left;
        stall_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req   = 1'b0;
                stall_left = 300;
            end
            if (stall_left > 0) begin
                stall_left--;
                i_m_tready <= 1'b0;
            end else if (!calm && $urandom_range(0, 3) == 0) begin
                stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                         : $urandom_range(0, 2);
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        t_status act;
        t_status exp_s;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            act = t_status'(o_m_tdata);
            results_out++;
            if (pending_status.size() == 0) begin
                $display("%0t: unexpected transfer, got %h", $time, o_m_tdata);
                mismatches++;
            end else begin
                exp_s = pending_status.pop_front();
                check_field("scl_drive", exp_s.scl, act.scl);
                check_field("sda_release", exp_s.sda, act.sda);
                check_field("busy", exp_s.busy, act.busy);
                check_field("done", exp_s.done, act.done);
                check_field("read_byte", exp_s.rd_byte, act.rd_byte);
                check_field("start_fault", exp_s.fault, act.fault);
                check_field("nack_seen", exp_s.nack, act.nack);
                check_field("command_dropped", exp_s.dropped, act.dropped);
            end
        end
    end

    initial begin
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_wdata = '0;
        i_s_tvalid  = 1'b0;
        i_s_tdata   = '0;
        i_s_tuser   = OP_TICK;
        i_m_tready  = 1'b0;
        mismatches  = 0;
        items_in    = 0;
        results_out = 0;
        n_cmds      = 0;
        n_dropped   = 0;
        n_done      = 0;
        calm        = 1'b0;
        hold_req    = 1'b0;
        predictor_reset();
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < N_ROWS; i++) begin
            send_item(plan[i].op, plan[i].dev, plan[i].rg, plan[i].dat, plan[i].sda,
                      plan[i].typed, plan[i].want);
            if (plan[i].settle) finish_txn();
        end

        for (int p = 0; p < 4; p++) begin
            set_phase_ticks(PHASE_SET[p]);
            calm = (p == 2);
            if (p == 1) hold_req = 1'b1;
            run_phase(PHASE_BUDGET, 1'b1);
        end

        // slowest setting: a transaction that cannot finish within the run
        set_phase_ticks(16'hFFFF);
        calm = 1'b0;
        run_phase(100, 1'b0);

        wait_drained();
        repeat (10) @(posedge i_clk);
        $display("%0d items in, %0d results out; %0d commands, %0d dropped, %0d completed",
                 items_in, results_out, n_cmds, n_dropped, n_done);
        $display("phase ticks 0 to 65535, long output hold-off, drained pauses");
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
